>>> rtl/core/jsq_pkg.sv
// Shared types and codes for the two-queue shortest-join dispatcher.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package jsq_pkg;

    localparam logic [1:0] K_SERVE1 = 2'd0;
    localparam logic [1:0] K_SERVE2 = 2'd1;
    localparam logic [1:0] K_JOIN   = 2'd2;
    localparam logic [1:0] K_LEAVE  = 2'd3;

    localparam logic [1:0] Q_NONE = 2'd0;
    localparam logic [1:0] Q_ONE  = 2'd1;
    localparam logic [1:0] Q_TWO  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SERVE,
        S_LOOK,
        S_SRCH,
        S_CMP,
        S_SHRD,
        S_SHWR
    } t_state;

endpackage
`default_nettype wire

>>> rtl/core/jsq_qmem.sv
// Queue store: both queues in one synchronous memory, queue select as top address bit.
// One write and one registered read per cycle. Uses jsq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jsq_qmem
    import jsq_pkg::*;
#(
    parameter int QW = 8,
    parameter int ID_BITS = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [QW:0]        i_waddr,
    input  wire logic [ID_BITS-1:0] i_wdata,
    input  wire logic               i_re,
    input  wire logic [QW:0]        i_raddr,
    output logic      [ID_BITS-1:0] o_rdata
);

    logic [ID_BITS-1:0] r_mem [0:(2 << QW)-1];
    logic [ID_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/core/jsq_map.sv
// Holder map: which queue last took each id, in a synchronous memory.
// After reset a clearing pass writes zero to every entry. Uses jsq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jsq_map
    import jsq_pkg::*;
#(
    parameter int ID_BITS = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_we,
    input  wire logic [ID_BITS-1:0] i_waddr,
    input  wire logic [1:0]         i_wdata,
    input  wire logic [ID_BITS-1:0] i_raddr,
    output logic      [1:0]         o_rdata,
    output logic                    o_busy
);

    logic [1:0]         r_mem [0:(1 << ID_BITS)-1];
    logic [1:0]         r_rdata;
    logic               r_busy;
    logic [ID_BITS-1:0] r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_clr  <= '0;
        end else if (r_busy) begin
            r_clr <= r_clr + 1'b1;
            if (&r_clr) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr] <= Q_NONE;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule
`default_nettype wire

>>> rtl/core/two_queue_shortest_join_dispatcher.sv
// Top level of the two-queue shortest-join dispatcher: sequencer and result register.
// Instantiates jsq_qmem and jsq_map; uses jsq_pkg.
//
//  channel   direction  handshake          payload
//  request   in         i_valid/o_ready    i_kind, i_customer_id
//  result    out        o_valid/i_ready    o_served_id, o_assigned_queue,
//                                          o_was_empty, o_was_full
//
// A join or a serve of an empty queue is settled in the idle state; a serve reads the
// head first; a leave looks up the map, searches the queue and shifts later entries to
// close the gap. After reset the map is cleared before the first request is taken.
// A waiting result that the receiver has not taken holds back every request.
`timescale 1ns / 1ps
`default_nettype none
module two_queue_shortest_join_dispatcher
    import jsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256,
    parameter int ID_BITS = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_kind,
    input  wire logic [ID_BITS-1:0] i_customer_id,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic      [ID_BITS-1:0] o_served_id,
    output logic      [1:0]         o_assigned_queue,
    output logic                    o_was_empty,
    output logic                    o_was_full
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = ((QW > LW) ? QW : LW) + 2;
    localparam logic [LW-1:0] FULL_LEN = LW'(QUEUE_DEPTH);

    t_state             r_state, n_state;
    logic [LW-1:0]      r_len1, r_len2;
    logic [QW-1:0]      r_head1, r_head2;
    logic               r_q, n_q;
    logic [ID_BITS-1:0] r_id, n_id;
    logic [LW-1:0]      r_j, n_j;
    logic               r_ov;
    logic [ID_BITS-1:0] r_served;
    logic [1:0]         r_assigned;
    logic               r_empty, r_full;

    logic               out_set;
    logic [ID_BITS-1:0] out_served;
    logic [1:0]         out_assigned;
    logic               out_empty, out_full;
    logic               slot_free, acc;

    logic               len_inc, len_dec, head_inc;
    logic               len_q;

    logic               q_we, q_re;
    logic [QW:0]        q_waddr, q_raddr;
    logic [ID_BITS-1:0] q_wdata, q_rdata;
    logic               m_we, m_busy;
    logic [ID_BITS-1:0] m_waddr, m_raddr;
    logic [1:0]         m_wdata, m_rdata;

    logic [LW-1:0]      cur_len;
    logic [QW-1:0]      cur_head;
    logic               pick_first;
    logic [LW:0]        j1, j2;

    function automatic logic [QW-1:0] phys(input logic [QW-1:0] head,
                                           input logic [LW-1:0] off);
        logic [AW-1:0] s;
        s = AW'(head) + AW'(off);
        if (s >= AW'(QUEUE_DEPTH)) begin
            s = s - AW'(QUEUE_DEPTH);
        end
        return s[QW-1:0];
    endfunction

    assign cur_len    = r_q ? r_len2 : r_len1;
    assign cur_head   = r_q ? r_head2 : r_head1;
    assign pick_first = (r_len1 <= r_len2);
    assign j1         = {1'b0, r_j} + 1'b1;
    assign j2         = {1'b0, r_j} + 2'd2;
    assign slot_free  = !r_ov || i_ready;
    assign o_ready    = (r_state == S_IDLE) && !m_busy && slot_free;
    assign acc        = i_valid && o_ready;

    always_comb begin
        n_state      = r_state;
        n_q          = r_q;
        n_id         = r_id;
        n_j          = r_j;
        out_set      = 1'b0;
        out_served   = '0;
        out_assigned = Q_NONE;
        out_empty    = 1'b0;
        out_full     = 1'b0;
        len_inc      = 1'b0;
        len_dec      = 1'b0;
        head_inc     = 1'b0;
        len_q        = r_q;
        q_we         = 1'b0;
        q_waddr      = '0;
        q_wdata      = '0;
        q_re         = 1'b0;
        q_raddr      = '0;
        m_we         = 1'b0;
        m_waddr      = r_id;
        m_wdata      = Q_NONE;
        m_raddr      = i_customer_id;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    unique case (i_kind)
                        K_SERVE1, K_SERVE2: begin
                            n_q = (i_kind == K_SERVE2);
                            if ((i_kind == K_SERVE2 ? r_len2 : r_len1) == '0) begin
                                out_set   = 1'b1;
                                out_empty = 1'b1;
                            end else begin
                                q_re    = 1'b1;
                                q_raddr = {n_q, (n_q ? r_head2 : r_head1)};
                                n_state = S_SERVE;
                            end
                        end
                        K_JOIN: begin
                            out_set = 1'b1;
                            len_q   = !pick_first;
                            if ((pick_first ? r_len1 : r_len2) == FULL_LEN) begin
                                out_full = 1'b1;
                            end else begin
                                len_inc      = 1'b1;
                                q_we         = 1'b1;
                                q_waddr      = pick_first ? {1'b0, phys(r_head1, r_len1)}
                                                          : {1'b1, phys(r_head2, r_len2)};
                                q_wdata      = i_customer_id;
                                m_we         = 1'b1;
                                m_waddr      = i_customer_id;
                                m_wdata      = pick_first ? Q_ONE : Q_TWO;
                                out_assigned = m_wdata;
                            end
                        end
                        default: begin
                            n_id    = i_customer_id;
                            n_state = S_LOOK;
                        end
                    endcase
                end
            end
            S_SERVE: begin
                if (slot_free) begin
                    out_set    = 1'b1;
                    out_served = q_rdata;
                    m_we       = 1'b1;
                    m_waddr    = q_rdata;
                    len_dec    = 1'b1;
                    head_inc   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_LOOK: begin
                n_j = '0;
                if (m_rdata == Q_ONE || m_rdata == Q_TWO) begin
                    n_q = (m_rdata == Q_TWO);
                    if ((n_q ? r_len2 : r_len1) == '0) begin
                        m_we    = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SRCH;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SRCH: begin
                q_re    = 1'b1;
                q_raddr = {r_q, phys(cur_head, r_j)};
                n_state = S_CMP;
            end
            S_CMP: begin
                if (q_rdata == r_id) begin
                    if (j1 < {1'b0, cur_len}) begin
                        n_state = S_SHRD;
                    end else begin
                        len_dec = 1'b1;
                        m_we    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (j1 < {1'b0, cur_len}) begin
                    n_j     = j1[LW-1:0];
                    n_state = S_SRCH;
                end else begin
                    // Mapped but absent: the map entry is cleared all the same.
                    m_we    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SHRD: begin
                q_re    = 1'b1;
                q_raddr = {r_q, phys(cur_head, j1[LW-1:0])};
                n_state = S_SHWR;
            end
            S_SHWR: begin
                q_we    = 1'b1;
                q_waddr = {r_q, phys(cur_head, r_j)};
                q_wdata = q_rdata;
                n_j     = j1[LW-1:0];
                if (j2 < {1'b0, cur_len}) begin
                    n_state = S_SHRD;
                end else begin
                    len_dec = 1'b1;
                    m_we    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len1  <= '0;
            r_len2  <= '0;
            r_head1 <= '0;
            r_head2 <= '0;
            r_ov    <= 1'b0;
            r_q     <= 1'b0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_q     <= n_q;
            r_j     <= n_j;
            if (len_inc) begin
                if (len_q) r_len2 <= r_len2 + 1'b1;
                else       r_len1 <= r_len1 + 1'b1;
            end
            if (len_dec) begin
                if (len_q) r_len2 <= r_len2 - 1'b1;
                else       r_len1 <= r_len1 - 1'b1;
            end
            if (head_inc) begin
                if (r_q) begin
                    r_head2 <= (32'(r_head2) == QUEUE_DEPTH - 1) ? '0 : r_head2 + 1'b1;
                end else begin
                    r_head1 <= (32'(r_head1) == QUEUE_DEPTH - 1) ? '0 : r_head1 + 1'b1;
                end
            end
            if (out_set) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
        if (out_set) begin
            r_served   <= out_served;
            r_assigned <= out_assigned;
            r_empty    <= out_empty;
            r_full     <= out_full;
        end
    end

    jsq_qmem #(
        .QW      (QW),
        .ID_BITS (ID_BITS)
    ) u_qmem (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_re    (q_re),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    jsq_map #(
        .ID_BITS (ID_BITS)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata),
        .o_busy  (m_busy)
    );

    assign o_valid          = r_ov;
    assign o_served_id      = r_served;
    assign o_assigned_queue = r_assigned;
    assign o_was_empty      = r_empty;
    assign o_was_full       = r_full;

`ifndef SYNTH
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len1 <= FULL_LEN) && (r_len2 <= FULL_LEN))
        else $error("queue length beyond depth");
    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_was_empty, o_was_full, o_assigned_queue != Q_NONE}) <= 1)
        else $error("result carries more than one outcome");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_state == S_IDLE) && !m_busy)
        else $error("request taken while busy");
    a_serve_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SERVE && slot_free) |=> $past(cur_len) != '0)
        else $error("serve from an empty queue");
`endif

endmodule
`default_nettype wire
